// ===== rtl/ssoi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssoi_pkg: shared types and constants of the skid-steer odometry integrator
// Item, result and configuration records, fixed-point constants, defaults.
// ----------------------------------------------------------------------------
package ssoi_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int POSITION_BITS_DEF = 48;
	localparam int QUEUE_DEPTH       = 2;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_TRACK = 4'd1;
	localparam logic [15:0] WHEEL_RADIUS_RST  = 16'd6554;
	localparam logic [23:0] INVERSE_TRACK_RST = 24'd131072;

	localparam int POS_OUT_W = 48;

	// shared multiplier operand width
	localparam int MUL_W = 34;
	localparam logic signed [MUL_W-1:0] WHEEL_K = 34'sd449767923;
	localparam logic signed [MUL_W-1:0] POLY_A  = 34'sd1686629713;
	localparam logic signed [MUL_W-1:0] POLY_B  = 34'sd688904866;
	localparam logic signed [MUL_W-1:0] POLY_C  = 34'sd76016977;

	// displacement divide by 1e6, four quotient bits per cycle over 56 bits
	localparam logic [20:0] DIVISOR   = 21'd1000000;
	localparam int          DIV_STEPS = 14;
	localparam int          DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic {
		KIND_STEP,
		KIND_RESTART
	} kind_t;

	typedef struct packed {
		logic [15:0] wheel_radius;
		logic [23:0] inverse_track;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] rpm_front_right;
		logic signed [15:0] rpm_rear_right;
		logic signed [15:0] rpm_rear_left;
		logic signed [15:0] rpm_front_left;
		logic [15:0]        yaw_angle;
		logic signed [31:0] yaw_rate;
		logic [19:0]        elapsed_us;
		logic               imu_ready;
	} item_t;

	typedef struct packed {
		logic [47:0] local_x;
		logic [47:0] local_y;
		logic [47:0] global_x;
		logic [47:0] global_y;
		logic [31:0] forward_speed;
		logic [31:0] corrected_speed;
		logic [31:0] turn_rate;
		logic [15:0] relative_yaw;
		logic        publish;
	} result_t;

endpackage

// ===== rtl/skid_steer_odometry_integrator.sv =====
// Step item: multiplier slots on one shared multiplier in the sequencer,
// a divide at four quotient bits a cycle, then one update. The sequencer
// takes no new item until it is through with the last. Restart item: taken
// and answered in the idle state. Two items queued on each side.
// Reset (arst_n low, asynchronous): queues empty, pose and yaw offset zero,
// registers at their defaults.
// ----------------------------------------------------------------------------
// skid_steer_odometry_integrator: wheel odometry dead reckoning
// Intake queue, odometry sequencer, result queue and configuration registers.
// ----------------------------------------------------------------------------
module skid_steer_odometry_integrator #(
	parameter int ANGLE_BITS    = ssoi_pkg::ANGLE_BITS_DEF,
	parameter int POSITION_BITS = ssoi_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssoi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssoi_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic                            operation,
	input  logic signed [15:0]              rpm_front_right,
	input  logic signed [15:0]              rpm_rear_right,
	input  logic signed [15:0]              rpm_rear_left,
	input  logic signed [15:0]              rpm_front_left,
	input  logic signed [15:0]              yaw_angle,
	input  logic signed [31:0]              yaw_rate,
	input  logic [19:0]                     elapsed_us,
	input  logic                            imu_ready,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [47:0]              local_x,
	output logic signed [47:0]              local_y,
	output logic signed [47:0]              global_x,
	output logic signed [47:0]              global_y,
	output logic signed [31:0]              forward_speed,
	output logic signed [31:0]              corrected_speed,
	output logic signed [31:0]              turn_rate,
	output logic signed [15:0]              relative_yaw,
	output logic                            publish
);

	ssoi_pkg::cfg_t        cfg_q;
	ssoi_pkg::item_t       item;
	ssoi_pkg::result_t     res, res_head;
	logic                  item_valid, item_take;
	logic                  res_push, res_full;
	logic [$bits(res)-1:0] res_bits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_radius  <= ssoi_pkg::WHEEL_RADIUS_RST;
			cfg_q.inverse_track <= ssoi_pkg::INVERSE_TRACK_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ssoi_pkg::CFG_WHEEL_RADIUS) begin
				cfg_q.wheel_radius <= cfg_data[15:0];
			end else if (cfg_index == ssoi_pkg::CFG_INVERSE_TRACK) begin
				cfg_q.inverse_track <= cfg_data[23:0];
			end
		end
	end

	ssoi_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.operation       (operation),
		.rpm_front_right (rpm_front_right),
		.rpm_rear_right  (rpm_rear_right),
		.rpm_rear_left   (rpm_rear_left),
		.rpm_front_left  (rpm_front_left),
		.yaw_angle       (yaw_angle),
		.yaw_rate        (yaw_rate),
		.elapsed_us      (elapsed_us),
		.imu_ready       (imu_ready),
		.item_valid      (item_valid),
		.item            (item),
		.item_take       (item_take)
	);

	ssoi_back #(
		.ANGLE_BITS    (ANGLE_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	ssoi_fifo #(
		.WIDTH ($bits(res)),
		.DEPTH (ssoi_pkg::QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_bits),
		.empty   (empty)
	);

	assign res_head        = ssoi_pkg::result_t'(res_bits);
	assign local_x         = res_head.local_x;
	assign local_y         = res_head.local_y;
	assign global_x        = res_head.global_x;
	assign global_y        = res_head.global_y;
	assign forward_speed   = res_head.forward_speed;
	assign corrected_speed = res_head.corrected_speed;
	assign turn_rate       = res_head.turn_rate;
	assign relative_yaw    = res_head.relative_yaw;
	assign publish         = res_head.publish;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result beat pushed into a full queue");

	a_take_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> item_valid)
		else $error("sequencer took an item from an empty queue");

	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && forward_speed == 32'sd0) |-> (corrected_speed == 32'sd0))
		else $error("corrected speed nonzero at zero forward speed");

endmodule

// ===== rtl/ssoi_fifo.sv =====
// ----------------------------------------------------------------------------
// ssoi_fifo: small register queue
// First-word-fall-through queue with full and empty flags.
// ----------------------------------------------------------------------------
module ssoi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ssoi_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/ssoi_front.sv =====
// ----------------------------------------------------------------------------
// ssoi_front: item intake
// Accepts input beats, tags them as step or restart and queues them.
// ----------------------------------------------------------------------------
module ssoi_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  operation,
	input  logic signed [15:0]    rpm_front_right,
	input  logic signed [15:0]    rpm_rear_right,
	input  logic signed [15:0]    rpm_rear_left,
	input  logic signed [15:0]    rpm_front_left,
	input  logic signed [15:0]    yaw_angle,
	input  logic signed [31:0]    yaw_rate,
	input  logic [19:0]           elapsed_us,
	input  logic                  imu_ready,
	output logic                  item_valid,
	output ssoi_pkg::item_t       item,
	input  logic                  item_take
);

	ssoi_pkg::item_t            in_item;
	logic [$bits(in_item)-1:0]  head;
	logic                       empty;

	always_comb begin
		in_item.kind            = operation ? ssoi_pkg::KIND_RESTART : ssoi_pkg::KIND_STEP;
		in_item.rpm_front_right = rpm_front_right;
		in_item.rpm_rear_right  = rpm_rear_right;
		in_item.rpm_rear_left   = rpm_rear_left;
		in_item.rpm_front_left  = rpm_front_left;
		in_item.yaw_angle       = yaw_angle;
		in_item.yaw_rate        = yaw_rate;
		in_item.elapsed_us      = elapsed_us;
		in_item.imu_ready       = imu_ready;
	end

	ssoi_fifo #(
		.WIDTH ($bits(in_item)),
		.DEPTH (ssoi_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_item),
		.full    (full),
		.rd_en   (item_take),
		.rd_data (head),
		.empty   (empty)
	);

	assign item_valid = !empty;
	assign item       = ssoi_pkg::item_t'(head);

endmodule

// ===== rtl/ssoi_back.sv =====
// ----------------------------------------------------------------------------
// ssoi_back: odometry sequencer
// Runs one item at a time through a shared multiplier and four divider lanes,
// holds the pose state and emits one result beat per item.
// ----------------------------------------------------------------------------
module ssoi_back #(
	parameter int ANGLE_BITS    = ssoi_pkg::ANGLE_BITS_DEF,
	parameter int POSITION_BITS = ssoi_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ssoi_pkg::cfg_t    cfg,
	input  logic              item_valid,
	input  ssoi_pkg::item_t   item,
	output logic              item_take,
	input  logic              res_full,
	output logic              res_push,
	output ssoi_pkg::result_t res
);

	localparam int MW = ssoi_pkg::MUL_W;
	localparam int A  = ANGLE_BITS;
	localparam int P  = POSITION_BITS;

	typedef enum logic [5:0] {
		S_IDLE, S_R0, S_K0, S_R1, S_K1, S_R2, S_K2, S_R3, S_K3,
		S_SP, S_Z, S_KIN, S_C0, S_C1, S_B0, S_B1, S_A0, S_A1, S_COR,
		S_D0, S_D1, S_D2, S_D3, S_U0, S_U1, S_U2, S_U3, S_U4, S_DIV, S_ACC
	} state_t;

	state_t state_q;

	ssoi_pkg::item_t          item_q;
	logic signed [MW-1:0]     mul_a, mul_b;
	logic signed [2*MW-1:0]   prod_q;
	logic signed [29:0]       prod_sh32;
	logic signed [31:0]       prod_sh28;
	logic signed [51:0]       prod_sh16;

	logic signed [29:0]       ws_fr_q, ws_rr_q, ws_rl_q;
	logic signed [29:0]       right_q, left_q, fwd_q;
	logic signed [30:0]       diff_q, cor_q;
	logic signed [38:0]       kin_q;
	logic [16:0]              alpha_c;
	logic signed [15:0]       s_sin_q, s_cos_q;
	logic [28:0]              z2s_q, z2c_q;
	logic signed [30:0]       t2s_q, t2c_q;
	logic signed [31:0]       t4s_q, t4c_q;
	logic signed [17:0]       sn_q, cs_q;
	logic signed [32:0]       p_q   [4];
	logic [55:0]              mag_q [4];
	logic [55:0]              mag_n [4];
	logic [19:0]              rem_q [4];
	logic [19:0]              rem_n [4];
	logic                     neg_q [4];
	logic signed [34:0]       d_c   [4];
	logic [ssoi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [1:0]               lane;
	logic signed [53:0]       n_c;
	logic [55:0]              mag_c;

	logic [A-1:0]             yaw_off_q, rel_q, rel_c;
	logic [15:0]              a16_c;
	logic [P-1:0]             loc_x_q, loc_y_q, glb_x_q, glb_y_q;
	logic [P-1:0]             nlx, nly, ngx, ngy;

	function automatic logic signed [15:0] fold_quarter(input logic [15:0] a);
		logic signed [17:0] s;
		s = 18'($signed(a));
		if (s > 18'sd16384) begin
			s = 18'sd32768 - s;
		end else if (s < -18'sd16384) begin
			s = -18'sd32768 - s;
		end
		return 16'(s);
	endfunction

	assign prod_sh32 = 30'(prod_q >>> 32);
	assign prod_sh28 = 32'(prod_q >>> 28);
	assign prod_sh16 = 52'(prod_q >>> 16);
	assign n_c       = 54'(prod_q);
	assign mag_c     = n_c[53] ? 56'(-n_c) : 56'(n_c);

	assign rel_c = A'(item.yaw_angle) - yaw_off_q;
	assign a16_c = 16'({rel_c, 16'b0} >> ANGLE_BITS);

	always_comb begin
		logic signed [41:0] h;
		logic signed [41:0] al;
		h  = (42'(kin_q) - 42'(item_q.yaw_rate)) >>> 1;
		al = 42'sd65536 - h;
		if (kin_q == '0) begin
			alpha_c = 17'd65536;
		end else if (al < 0) begin
			alpha_c = '0;
		end else if (al > 42'sd65536) begin
			alpha_c = 17'd65536;
		end else begin
			alpha_c = 17'(al);
		end
	end

	always_comb begin
		unique case (state_q)
			S_U1:    lane = 2'd0;
			S_U2:    lane = 2'd1;
			S_U3:    lane = 2'd2;
			default: lane = 2'd3;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_R0: begin
				mul_a = MW'({1'b0, cfg.wheel_radius});
				mul_b = MW'(item_q.rpm_front_right);
			end
			S_R1: begin
				mul_a = MW'({1'b0, cfg.wheel_radius});
				mul_b = MW'(item_q.rpm_rear_right);
			end
			S_R2: begin
				mul_a = MW'({1'b0, cfg.wheel_radius});
				mul_b = MW'(item_q.rpm_rear_left);
			end
			S_R3: begin
				mul_a = MW'({1'b0, cfg.wheel_radius});
				mul_b = MW'(item_q.rpm_front_left);
			end
			S_K0, S_K1, S_K2, S_K3: begin
				mul_a = MW'($signed(prod_q[31:0]));
				mul_b = ssoi_pkg::WHEEL_K;
			end
			S_SP: begin
				mul_a = MW'(s_sin_q);
				mul_b = MW'(s_sin_q);
			end
			S_Z: begin
				mul_a = MW'(s_cos_q);
				mul_b = MW'(s_cos_q);
			end
			S_KIN: begin
				mul_a = MW'(diff_q);
				mul_b = MW'({1'b0, cfg.inverse_track});
			end
			S_C0: begin
				mul_a = ssoi_pkg::POLY_C;
				mul_b = MW'(z2s_q);
			end
			S_C1: begin
				mul_a = ssoi_pkg::POLY_C;
				mul_b = MW'(z2c_q);
			end
			S_B0: begin
				mul_a = MW'(t2s_q);
				mul_b = MW'(z2s_q);
			end
			S_B1: begin
				mul_a = MW'(t2c_q);
				mul_b = MW'(z2c_q);
			end
			S_A0: begin
				mul_a = MW'(t4s_q);
				mul_b = MW'(s_sin_q);
			end
			S_A1: begin
				mul_a = MW'(t4c_q);
				mul_b = MW'(s_cos_q);
			end
			S_COR: begin
				mul_a = MW'(fwd_q);
				mul_b = MW'(alpha_c);
			end
			S_D0: begin
				mul_a = MW'(fwd_q);
				mul_b = MW'(cs_q);
			end
			S_D1: begin
				mul_a = MW'(fwd_q);
				mul_b = MW'(sn_q);
			end
			S_D2: begin
				mul_a = MW'(cor_q);
				mul_b = MW'(cs_q);
			end
			S_D3: begin
				mul_a = MW'(cor_q);
				mul_b = MW'(sn_q);
			end
			S_U0: begin
				mul_a = MW'(p_q[0]);
				mul_b = MW'(item_q.elapsed_us);
			end
			S_U1: begin
				mul_a = MW'(p_q[1]);
				mul_b = MW'(item_q.elapsed_us);
			end
			S_U2: begin
				mul_a = MW'(p_q[2]);
				mul_b = MW'(item_q.elapsed_us);
			end
			S_U3: begin
				mul_a = MW'(p_q[3]);
				mul_b = MW'(item_q.elapsed_us);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// restoring divide, four bits per lane per cycle
	always_comb begin
		logic [20:0] t;
		logic [19:0] r;
		logic [55:0] m;
		for (int k = 0; k < 4; k++) begin
			r = rem_q[k];
			m = mag_q[k];
			for (int j = 0; j < 4; j++) begin
				t = {r, m[55]};
				m = {m[54:0], 1'b0};
				if (t >= ssoi_pkg::DIVISOR) begin
					r    = 20'(t - ssoi_pkg::DIVISOR);
					m[0] = 1'b1;
				end else begin
					r = t[19:0];
				end
			end
			rem_n[k] = r;
			mag_n[k] = m;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			d_c[k] = neg_q[k] ? -35'(mag_q[k]) : 35'(mag_q[k]);
		end
	end

	assign nlx = loc_x_q + P'(d_c[0]);
	assign nly = loc_y_q + P'(d_c[1]);
	assign ngx = glb_x_q + P'(d_c[2]);
	assign ngy = glb_y_q + P'(d_c[3]);

	assign item_take = (state_q == S_IDLE) && item_valid
		&& ((item.kind == ssoi_pkg::KIND_STEP) || !res_full);
	assign res_push  = !res_full && ((state_q == S_ACC) || ((state_q == S_IDLE)
		&& item_valid && (item.kind == ssoi_pkg::KIND_RESTART)));

	always_comb begin
		if (state_q == S_ACC) begin
			res.local_x         = ssoi_pkg::POS_OUT_W'(nlx);
			res.local_y         = ssoi_pkg::POS_OUT_W'(nly);
			res.global_x        = ssoi_pkg::POS_OUT_W'(ngx);
			res.global_y        = ssoi_pkg::POS_OUT_W'(ngy);
			res.forward_speed   = 32'(fwd_q);
			res.corrected_speed = 32'(cor_q);
			res.turn_rate       = item_q.yaw_rate;
			res.relative_yaw    = 16'(rel_q);
			res.publish         = item_q.imu_ready;
		end else begin
			res.local_x         = '0;
			res.local_y         = '0;
			res.global_x        = ssoi_pkg::POS_OUT_W'(glb_x_q);
			res.global_y        = ssoi_pkg::POS_OUT_W'(glb_y_q);
			res.forward_speed   = '0;
			res.corrected_speed = '0;
			res.turn_rate       = item.yaw_rate;
			res.relative_yaw    = '0;
			res.publish         = 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q  <= item;
				rel_q   <= rel_c;
				s_sin_q <= fold_quarter(a16_c);
				s_cos_q <= fold_quarter(a16_c + 16'd16384);
			end
			S_R1: ws_fr_q <= prod_sh32;
			S_R2: ws_rr_q <= prod_sh32;
			S_R3: ws_rl_q <= prod_sh32;
			S_SP: begin
				right_q <= 30'((-(32'(ws_fr_q) + 32'(ws_rr_q))) >>> 1);
				left_q  <= 30'((32'(prod_sh32) + 32'(ws_rl_q)) >>> 1);
			end
			S_Z: begin
				z2s_q  <= 29'(prod_q);
				fwd_q  <= 30'((32'(right_q) + 32'(left_q)) >>> 1);
				diff_q <= 31'(32'(right_q) - 32'(left_q));
			end
			S_KIN: z2c_q <= 29'(prod_q);
			S_C0:  kin_q <= 39'(prod_sh16);
			S_C1:  t2s_q <= 31'(ssoi_pkg::POLY_B - MW'(prod_sh28));
			S_B0:  t2c_q <= 31'(ssoi_pkg::POLY_B - MW'(prod_sh28));
			S_B1:  t4s_q <= 32'(ssoi_pkg::POLY_A - MW'(prod_sh28));
			S_A0:  t4c_q <= 32'(ssoi_pkg::POLY_A - MW'(prod_sh28));
			S_A1:  sn_q  <= 18'(prod_sh28);
			S_COR: cs_q  <= 18'(prod_sh28);
			S_D0:  cor_q <= 31'(prod_sh16);
			S_D1:  p_q[0] <= 33'(prod_sh16);
			S_D2:  p_q[1] <= 33'(prod_sh16);
			S_D3:  p_q[2] <= 33'(prod_sh16);
			S_U0:  p_q[3] <= 33'(prod_sh16);
			S_U1, S_U2, S_U3, S_U4: begin
				mag_q[lane] <= mag_c;
				neg_q[lane] <= n_c[53];
				rem_q[lane] <= '0;
			end
			S_DIV: begin
				for (int k = 0; k < 4; k++) begin
					mag_q[k] <= mag_n[k];
					rem_q[k] <= rem_n[k];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			yaw_off_q <= '0;
			loc_x_q   <= '0;
			loc_y_q   <= '0;
			glb_x_q   <= '0;
			glb_y_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_take) begin
						if (item.kind == ssoi_pkg::KIND_RESTART) begin
							loc_x_q   <= '0;
							loc_y_q   <= '0;
							yaw_off_q <= A'(item.yaw_angle);
						end else begin
							state_q <= S_R0;
						end
					end
				end
				S_U4: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ssoi_pkg::DIV_CNT_W'(ssoi_pkg::DIV_STEPS - 1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (!res_full) begin
						loc_x_q <= nlx;
						loc_y_q <= nly;
						glb_x_q <= ngx;
						glb_y_q <= ngy;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= state_t'(state_q + 1'b1);
			endcase
		end
	end

endmodule

// ===== bench/skid_steer_odometry_integrator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skid_steer_odometry_integrator_tb: self-checking bench for the integrator
// Drives directed and random odometry steps and restarts under several
// register settings, predicts every beat in a fixed-point model of the pose
// integration and compares each result field by field.
// ----------------------------------------------------------------------------
module skid_steer_odometry_integrator_tb;
	import ssoi_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;
	localparam longint SPEED_K = 449767923;
	localparam longint SIN_A   = 1686629713;
	localparam longint SIN_B   = 688904866;
	localparam longint SIN_C   = 76016977;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic operation = 1'b0;
	logic signed [15:0] rpm_front_right = '0;
	logic signed [15:0] rpm_rear_right = '0;
	logic signed [15:0] rpm_rear_left = '0;
	logic signed [15:0] rpm_front_left = '0;
	logic signed [15:0] yaw_angle = '0;
	logic signed [31:0] yaw_rate = '0;
	logic [19:0] elapsed_us = '0;
	logic imu_ready = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [47:0] local_x, local_y, global_x, global_y;
	logic signed [31:0] forward_speed, corrected_speed, turn_rate;
	logic signed [15:0] relative_yaw;
	logic publish;

	skid_steer_odometry_integrator dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// predictor state
	logic [15:0] m_radius = WHEEL_RADIUS_RST;
	logic [23:0] m_inv_track = INVERSE_TRACK_RST;
	logic [15:0] m_yaw_offset = '0;
	logic [47:0] m_lx = '0, m_ly = '0, m_gx = '0, m_gy = '0;

	item_t pending[$];
	result_t pose_expected[$];
	item_t cur;
	int errors = 0;
	int n_steps = 0, n_restarts = 0, n_unpublished = 0, n_settings = 1;
	int n_results = 0;

	function automatic longint wheel_mps(logic signed [15:0] rpm);
		return (longint'(m_radius) * longint'(rpm) * SPEED_K) >>> 32;
	endfunction

	function automatic longint sine_q16(logic [15:0] a);
		longint s, z2, t;
		s = longint'($signed(a));
		if (s > 16384)
			s = 32768 - s;
		else if (s < -16384)
			s = -32768 - s;
		z2 = s * s;
		t = SIN_B - ((SIN_C * z2) >>> 28);
		t = SIN_A - ((t * z2) >>> 28);
		return (t * s) >>> 28;
	endfunction

	function automatic longint travel(longint speed, longint trig, logic [19:0] us);
		return ((speed * trig) >>> 16) * longint'(us) / 1000000;
	endfunction

	function automatic void advance_pose(item_t it);
		result_t r;
		longint fr, rr, rl, fl, right, left, kin, fwd, alpha, cor, sn, cs;
		logic [15:0] rel;
		r = '0;
		r.turn_rate = it.yaw_rate;
		r.publish = 1'b1;
		if (it.kind == KIND_RESTART) begin
			m_lx = '0;
			m_ly = '0;
			m_yaw_offset = it.yaw_angle;
			n_restarts++;
		end else begin
			fr = wheel_mps(it.rpm_front_right);
			rr = wheel_mps(it.rpm_rear_right);
			rl = wheel_mps(it.rpm_rear_left);
			fl = wheel_mps(it.rpm_front_left);
			right = (-(fr + rr)) >>> 1;
			left = (fl + rl) >>> 1;
			kin = ((right - left) * longint'(m_inv_track)) >>> 16;
			fwd = (right + left) >>> 1;
			if (fwd > 64'sd2147483647) fwd = 64'sd2147483647;
			if (fwd < -64'sd2147483648) fwd = -64'sd2147483648;
			alpha = 65536;
			if (kin != 0) begin
				alpha = 65536 - ((kin - longint'(it.yaw_rate)) >>> 1);
				if (alpha < 0) alpha = 0;
				if (alpha > 65536) alpha = 65536;
			end
			cor = (fwd * alpha) >>> 16;
			rel = it.yaw_angle - m_yaw_offset;
			sn = sine_q16(rel);
			cs = sine_q16(rel + 16'd16384);
			m_lx += 48'(travel(fwd, cs, it.elapsed_us));
			m_ly += 48'(travel(fwd, sn, it.elapsed_us));
			m_gx += 48'(travel(cor, cs, it.elapsed_us));
			m_gy += 48'(travel(cor, sn, it.elapsed_us));
			r.forward_speed = fwd[31:0];
			r.corrected_speed = cor[31:0];
			r.relative_yaw = rel;
			r.publish = it.imu_ready;
			n_steps++;
			if (!it.imu_ready) n_unpublished++;
		end
		r.local_x = m_lx;
		r.local_y = m_ly;
		r.global_x = m_gx;
		r.global_y = m_gy;
		pose_expected.push_back(r);
	endfunction

	// driver: bursts with random gaps
	int burst_left = 8, gap_left = 0;
	always @(posedge clk) begin
		if (push && !full) begin
			advance_pose(cur);
			void'(pending.pop_front());
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
			end
		end
		if (push && full) begin
		end else if (gap_left > 0) begin
			gap_left--;
			push <= 1'b0;
		end else if (pending.size() > 0) begin
			cur = pending[0];
			push <= 1'b1;
			operation <= cur.kind;
			rpm_front_right <= cur.rpm_front_right;
			rpm_rear_right <= cur.rpm_rear_right;
			rpm_rear_left <= cur.rpm_rear_left;
			rpm_front_left <= cur.rpm_front_left;
			yaw_angle <= cur.yaw_angle;
			yaw_rate <= cur.yaw_rate;
			elapsed_us <= cur.elapsed_us;
			imu_ready <= cur.imu_ready;
		end else
			push <= 1'b0;
	end

	// monitor: own stall pattern, one long hold-off
	int hold_left = 0;
	bit steady = 1'b0;
	always @(posedge clk) begin
		result_t e;
		if (pop && !empty) begin
			n_results++;
			if (pose_expected.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pose_expected.pop_front();
				if (local_x !== e.local_x) begin
					$error("local_x expected %h got %h", e.local_x, local_x); errors++;
				end
				if (local_y !== e.local_y) begin
					$error("local_y expected %h got %h", e.local_y, local_y); errors++;
				end
				if (global_x !== e.global_x) begin
					$error("global_x expected %h got %h", e.global_x, global_x); errors++;
				end
				if (global_y !== e.global_y) begin
					$error("global_y expected %h got %h", e.global_y, global_y); errors++;
				end
				if (forward_speed !== e.forward_speed) begin
					$error("forward_speed expected %h got %h", e.forward_speed,
						forward_speed); errors++;
				end
				if (corrected_speed !== e.corrected_speed) begin
					$error("corrected_speed expected %h got %h", e.corrected_speed,
						corrected_speed); errors++;
				end
				if (turn_rate !== e.turn_rate) begin
					$error("turn_rate expected %h got %h", e.turn_rate, turn_rate); errors++;
				end
				if (relative_yaw !== e.relative_yaw) begin
					$error("relative_yaw expected %h got %h", e.relative_yaw,
						relative_yaw); errors++;
				end
				if (publish !== e.publish) begin
					$error("publish expected %h got %h", e.publish, publish); errors++;
				end
			end
			if (n_results == 200)
				hold_left = 1500;
			if (n_results % 64 == 0)
				steady = ~steady;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (steady)
			pop <= 1'b1;
		else
			pop <= ($urandom_range(0, 3) != 0);
	end

	function automatic item_t mk(kind_t k, int fr, int rr, int rl, int fl, int yaw,
		int rate, int us, bit imu);
		item_t it;
		it.kind = k;
		it.rpm_front_right = fr;
		it.rpm_rear_right = rr;
		it.rpm_rear_left = rl;
		it.rpm_front_left = fl;
		it.yaw_angle = yaw;
		it.yaw_rate = rate;
		it.elapsed_us = us;
		it.imu_ready = imu;
		return it;
	endfunction

	function automatic int rand_rpm();
		return ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 8000) - 4000;
	endfunction

	function automatic item_t rand_item();
		return mk(($urandom_range(0, 19) == 0) ? KIND_RESTART : KIND_STEP,
			rand_rpm(), rand_rpm(), rand_rpm(), rand_rpm(), $urandom,
			($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 262144) - 131072,
			($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 100000),
			$urandom_range(0, 7) != 0);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_WHEEL_RADIUS)
			m_radius = val[15:0];
		else if (idx == CFG_INVERSE_TRACK)
			m_inv_track = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (pending.size() > 0 || pose_expected.size() > 0 || push)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		repeat (n) pending.push_back(rand_item());
		settle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		pending.push_back(mk(KIND_STEP, 0, 0, 0, 0, 0, 0, 100000, 1));
		pending.push_back(mk(KIND_STEP, 1000, 1000, 1000, 1000, 0, 0, 50000, 1));
		pending.push_back(mk(KIND_STEP, -1000, -1000, 1000, 1000, 16384, 0, 50000, 1));
		pending.push_back(mk(KIND_STEP, 32767, 32767, 32767, 32767, -32768,
			32'sh7fffffff, 20'hfffff, 1));
		pending.push_back(mk(KIND_STEP, -32768, -32768, -32768, -32768, 32767,
			32'sh80000000, 20'hfffff, 1));
		pending.push_back(mk(KIND_STEP, -32768, -32768, 32767, 32767, -16384,
			32'sh80000000, 20'hfffff, 0));
		pending.push_back(mk(KIND_STEP, 32767, 32767, -32768, -32768, 8192,
			32'sh7fffffff, 0, 0));
		pending.push_back(mk(KIND_STEP, 3000, -3000, 2000, -2000, -1, 65536, 1, 1));
		pending.push_back(mk(KIND_STEP, 500, 400, -300, 200, 24576, -65536, 50000, 0));
		pending.push_back(mk(KIND_RESTART, 1234, -1234, 55, -55, 12345, -777, 999, 0));
		pending.push_back(mk(KIND_STEP, -2000, -2000, 2000, 2000, 12345, 0, 50000, 1));
		pending.push_back(mk(KIND_STEP, -2000, -2000, 2000, 2000, -20000, 0, 50000, 1));
		pending.push_back(mk(KIND_RESTART, 0, 0, 0, 0, -32768, 32'sh7fffffff, 0, 1));
		pending.push_back(mk(KIND_STEP, 100, 100, 100, 100, 32767, 3, 1000, 1));
		settle();

		random_phase(400);
		write_reg(CFG_WHEEL_RADIUS, 24'hffffff);
		write_reg(CFG_INVERSE_TRACK, 24'hffffff);
		n_settings++;
		random_phase(400);
		write_reg(CFG_WHEEL_RADIUS, 24'h0);
		write_reg(CFG_INVERSE_TRACK, 24'h0);
		n_settings++;
		random_phase(300);
		write_reg(CFG_WHEEL_RADIUS, $urandom);
		write_reg(CFG_INVERSE_TRACK, $urandom);
		write_reg(CFG_UNUSED_IDX, $urandom);
		n_settings++;
		random_phase(400);
		write_reg(CFG_WHEEL_RADIUS, WHEEL_RADIUS_RST);
		write_reg(CFG_INVERSE_TRACK, $urandom_range(0, 400000));
		n_settings++;
		random_phase(450);

		if (pose_expected.size() != 0) begin
			$error("%0d expected results never arrived", pose_expected.size());
			errors++;
		end
		$display("Covered %0d odometry steps (%0d without IMU) and %0d restarts",
			n_steps, n_unpublished, n_restarts);
		$display("across %0d register settings, %0d result beats checked",
			n_settings, n_results);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
